>>> rtl/tbi_pkg.sv
`default_nettype none

package tbi_pkg;

  // kind of a queued request
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_t;

  // micro-operations of the back-end sequencer
  typedef enum logic [2:0] {
    OP_SUB,
    OP_MUL,
    OP_MLA,
    OP_MLS,
    OP_CHKD,
    OP_DIV,
    OP_END
  } op_t;

  // back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PWR,
    ST_FETCH,
    ST_EXEC,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_DIV,
    ST_DFIN,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] d;
    logic [5:0] s1;
    logic [5:0] s2;
  } uinstr_t;

  localparam int ADDR_W    = 6;
  localparam int SCR_DEPTH = 64;
  localparam int UC_LEN    = 77;

  // scratch layout: vertex k position at 3k, velocity at 12+3k, query point at 24
  localparam logic [5:0] A_POS_A = 6'd0;
  localparam logic [5:0] A_POS_B = 6'd3;
  localparam logic [5:0] A_POS_C = 6'd6;
  localparam logic [5:0] A_POS_D = 6'd9;
  localparam logic [5:0] A_VEL   = 6'd12;
  localparam logic [5:0] A_VEL_1 = 6'd15;
  localparam logic [5:0] A_VEL_2 = 6'd18;
  localparam logic [5:0] A_VEL_3 = 6'd21;
  localparam logic [5:0] A_P     = 6'd24;
  localparam logic [5:0] A_BA    = 6'd27;
  localparam logic [5:0] A_CA    = 6'd30;
  localparam logic [5:0] A_DC    = 6'd33;
  localparam logic [5:0] A_PA    = 6'd36;
  localparam logic [5:0] A_CP    = 6'd39;
  localparam logic [5:0] A_BP    = 6'd42;
  localparam logic [5:0] A_DP    = 6'd45;
  localparam logic [5:0] A_CR    = 6'd48;
  localparam logic [5:0] A_D     = 6'd51;
  localparam logic [5:0] A_W0    = 6'd52;
  localparam logic [5:0] A_W1    = 6'd53;
  localparam logic [5:0] A_W2    = 6'd54;
  localparam logic [5:0] A_W3    = 6'd55;
  localparam logic [5:0] A_T     = 6'd56;

  function automatic uinstr_t ui(input op_t op, input logic [5:0] d,
                                 input logic [5:0] s1, input logic [5:0] s2);
    uinstr_t r;
    r.op = op;
    r.d  = d;
    r.s1 = s1;
    r.s2 = s2;
    return r;
  endfunction

  // one step of cross(u, v) into the cross temp
  function automatic uinstr_t xp(input logic [2:0] st, input logic [5:0] u,
                                 input logic [5:0] v);
    uinstr_t r;
    case (st)
      3'd0:    r = ui(OP_MUL, A_CR,        u + 6'd1, v + 6'd2);
      3'd1:    r = ui(OP_MLS, A_CR,        u + 6'd2, v + 6'd1);
      3'd2:    r = ui(OP_MUL, A_CR + 6'd1, u + 6'd2, v);
      3'd3:    r = ui(OP_MLS, A_CR + 6'd1, u,        v + 6'd2);
      3'd4:    r = ui(OP_MUL, A_CR + 6'd2, u,        v + 6'd1);
      default: r = ui(OP_MLS, A_CR + 6'd2, u + 6'd1, v);
    endcase
    return r;
  endfunction

  // one step of dot(cross temp, t) into dst
  function automatic uinstr_t dp(input logic [1:0] st, input logic [5:0] t,
                                 input logic [5:0] dst);
    uinstr_t r;
    case (st)
      2'd0:    r = ui(OP_MUL, dst, A_CR,        t);
      2'd1:    r = ui(OP_MLA, dst, A_CR + 6'd1, t + 6'd1);
      default: r = ui(OP_MLA, dst, A_CR + 6'd2, t + 6'd2);
    endcase
    return r;
  endfunction

  // query program
  function automatic uinstr_t ucode(input logic [6:0] pc);
    uinstr_t r;
    case (pc)
      7'd0:  r = ui(OP_SUB, A_BA,        A_POS_B,        A_POS_A);
      7'd1:  r = ui(OP_SUB, A_BA + 6'd1, A_POS_B + 6'd1, A_POS_A + 6'd1);
      7'd2:  r = ui(OP_SUB, A_BA + 6'd2, A_POS_B + 6'd2, A_POS_A + 6'd2);
      7'd3:  r = ui(OP_SUB, A_CA,        A_POS_C,        A_POS_A);
      7'd4:  r = ui(OP_SUB, A_CA + 6'd1, A_POS_C + 6'd1, A_POS_A + 6'd1);
      7'd5:  r = ui(OP_SUB, A_CA + 6'd2, A_POS_C + 6'd2, A_POS_A + 6'd2);
      7'd6:  r = ui(OP_SUB, A_DC,        A_POS_D,        A_POS_C);
      7'd7:  r = ui(OP_SUB, A_DC + 6'd1, A_POS_D + 6'd1, A_POS_C + 6'd1);
      7'd8:  r = ui(OP_SUB, A_DC + 6'd2, A_POS_D + 6'd2, A_POS_C + 6'd2);
      7'd9:  r = ui(OP_SUB, A_PA,        A_P,            A_POS_A);
      7'd10: r = ui(OP_SUB, A_PA + 6'd1, A_P + 6'd1,     A_POS_A + 6'd1);
      7'd11: r = ui(OP_SUB, A_PA + 6'd2, A_P + 6'd2,     A_POS_A + 6'd2);
      7'd12: r = ui(OP_SUB, A_CP,        A_POS_C,        A_P);
      7'd13: r = ui(OP_SUB, A_CP + 6'd1, A_POS_C + 6'd1, A_P + 6'd1);
      7'd14: r = ui(OP_SUB, A_CP + 6'd2, A_POS_C + 6'd2, A_P + 6'd2);
      7'd15: r = ui(OP_SUB, A_BP,        A_POS_B,        A_P);
      7'd16: r = ui(OP_SUB, A_BP + 6'd1, A_POS_B + 6'd1, A_P + 6'd1);
      7'd17: r = ui(OP_SUB, A_BP + 6'd2, A_POS_B + 6'd2, A_P + 6'd2);
      7'd18: r = ui(OP_SUB, A_DP,        A_POS_D,        A_P);
      7'd19: r = ui(OP_SUB, A_DP + 6'd1, A_POS_D + 6'd1, A_P + 6'd1);
      7'd20: r = ui(OP_SUB, A_DP + 6'd2, A_POS_D + 6'd2, A_P + 6'd2);
      // volume term
      7'd21: r = xp(3'd0, A_BA, A_DC);
      7'd22: r = xp(3'd1, A_BA, A_DC);
      7'd23: r = xp(3'd2, A_BA, A_DC);
      7'd24: r = xp(3'd3, A_BA, A_DC);
      7'd25: r = xp(3'd4, A_BA, A_DC);
      7'd26: r = xp(3'd5, A_BA, A_DC);
      7'd27: r = dp(2'd0, A_CA, A_D);
      7'd28: r = dp(2'd1, A_CA, A_D);
      7'd29: r = dp(2'd2, A_CA, A_D);
      7'd30: r = ui(OP_CHKD, A_D, A_D, A_D);
      // first weight
      7'd31: r = xp(3'd0, A_BP, A_DC);
      7'd32: r = xp(3'd1, A_BP, A_DC);
      7'd33: r = xp(3'd2, A_BP, A_DC);
      7'd34: r = xp(3'd3, A_BP, A_DC);
      7'd35: r = xp(3'd4, A_BP, A_DC);
      7'd36: r = xp(3'd5, A_BP, A_DC);
      7'd37: r = dp(2'd0, A_CP, A_W0);
      7'd38: r = dp(2'd1, A_CP, A_W0);
      7'd39: r = dp(2'd2, A_CP, A_W0);
      // second weight
      7'd40: r = xp(3'd0, A_PA, A_DC);
      7'd41: r = xp(3'd1, A_PA, A_DC);
      7'd42: r = xp(3'd2, A_PA, A_DC);
      7'd43: r = xp(3'd3, A_PA, A_DC);
      7'd44: r = xp(3'd4, A_PA, A_DC);
      7'd45: r = xp(3'd5, A_PA, A_DC);
      7'd46: r = dp(2'd0, A_CA, A_W1);
      7'd47: r = dp(2'd1, A_CA, A_W1);
      7'd48: r = dp(2'd2, A_CA, A_W1);
      // third weight
      7'd49: r = xp(3'd0, A_BA, A_DP);
      7'd50: r = xp(3'd1, A_BA, A_DP);
      7'd51: r = xp(3'd2, A_BA, A_DP);
      7'd52: r = xp(3'd3, A_BA, A_DP);
      7'd53: r = xp(3'd4, A_BA, A_DP);
      7'd54: r = xp(3'd5, A_BA, A_DP);
      7'd55: r = dp(2'd0, A_PA, A_W2);
      7'd56: r = dp(2'd1, A_PA, A_W2);
      7'd57: r = dp(2'd2, A_PA, A_W2);
      // last weight from the volume
      7'd58: r = ui(OP_SUB, A_W3, A_D,  A_W0);
      7'd59: r = ui(OP_SUB, A_W3, A_W3, A_W1);
      7'd60: r = ui(OP_SUB, A_W3, A_W3, A_W2);
      // x axis
      7'd61: r = ui(OP_MUL, A_T, A_W0, A_VEL);
      7'd62: r = ui(OP_MLA, A_T, A_W1, A_VEL_1);
      7'd63: r = ui(OP_MLA, A_T, A_W2, A_VEL_2);
      7'd64: r = ui(OP_MLA, A_T, A_W3, A_VEL_3);
      7'd65: r = ui(OP_DIV, 6'd0, A_T, A_T);
      // y axis
      7'd66: r = ui(OP_MUL, A_T, A_W0, A_VEL + 6'd1);
      7'd67: r = ui(OP_MLA, A_T, A_W1, A_VEL_1 + 6'd1);
      7'd68: r = ui(OP_MLA, A_T, A_W2, A_VEL_2 + 6'd1);
      7'd69: r = ui(OP_MLA, A_T, A_W3, A_VEL_3 + 6'd1);
      7'd70: r = ui(OP_DIV, 6'd1, A_T, A_T);
      // z axis
      7'd71: r = ui(OP_MUL, A_T, A_W0, A_VEL + 6'd2);
      7'd72: r = ui(OP_MLA, A_T, A_W1, A_VEL_1 + 6'd2);
      7'd73: r = ui(OP_MLA, A_T, A_W2, A_VEL_2 + 6'd2);
      7'd74: r = ui(OP_MLA, A_T, A_W3, A_VEL_3 + 6'd2);
      7'd75: r = ui(OP_DIV, 6'd2, A_T, A_T);
      default: r = ui(OP_END, 6'd0, 6'd0, 6'd0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tbi_front.sv
`default_nettype none

module tbi_front
  import tbi_pkg::*;
#(
  parameter int CW  = 20,
  parameter int INW = 128,
  parameter int EW  = 123
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [INW-1:0] in_tdata,
  input  wire logic           in_tuser,
  output logic                ent_valid,
  input  wire logic           ent_ready,
  output logic [EW-1:0]       ent_data
);

  logic          fv_r, fv_nxt;
  logic [EW-1:0] fd_r, fd_nxt;
  logic          accept;
  item_kind_t    kind;

  // classify the request: queries carry no velocity
  always_comb begin
    kind   = in_tuser ? KIND_QUERY : KIND_LOAD;
    fd_nxt = {in_tdata[2+6*CW-1:0], kind};
    if (kind == KIND_QUERY) begin
      fd_nxt[EW-1:3+3*CW] = '0;
    end
  end

  // one holding stage toward the queue
  assign in_tready = !fv_r || ent_ready;
  assign accept    = in_tvalid && in_tready;
  assign fv_nxt    = accept ? 1'b1 : (ent_ready ? 1'b0 : fv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fd_r <= fd_nxt;
    end
  end

  assign ent_valid = fv_r;
  assign ent_data  = fd_r;

endmodule

`default_nettype wire

>>> rtl/tbi_queue.sv
`default_nettype none

module tbi_queue
  import tbi_pkg::*;
#(
  parameter int EW = 123
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [EW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop,
  output logic [EW-1:0]      pop_data
);

  logic [EW-1:0] slot_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tbi_back.sv
`default_nettype none

module tbi_back
  import tbi_pkg::*;
#(
  parameter int CW   = 20,
  parameter int EW   = 123,
  parameter int OUTW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire logic [EW-1:0] q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [OUTW-1:0]    out_tdata,
  output logic [1:0]         out_tuser
);

  localparam int W    = 4 * CW + 10;
  localparam int DW   = 3 * CW + 6;
  localparam int CB   = CW + 3;
  localparam int PW   = 2 * CW + 6;
  localparam int CNTW = $clog2(W + 1);

  back_state_t state_r, state_nxt;
  uinstr_t     ins;

  logic [6:0]        pc_r;
  logic [CNTW-1:0]   cnt_r;
  logic [1:0]        ch_r;
  logic [W-1:0]      mem_r [SCR_DEPTH];
  logic [W-1:0]      rd1_r, rd2_r;
  logic [PW-1:0]     prod_r;
  logic [W-1:0]      msum_r, acc_r;
  logic [DW-1:0]     den_r;
  logic              dneg_r, qneg_r;
  logic [DW:0]       rem_r;
  logic [W-1:0]      q_r;
  logic [CW-1:0]     res_x_r, res_y_r, res_z_r;
  logic              sat_r, degen_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CW-1:0]     out_x_r, out_y_r, out_z_r;
  logic              out_degen_r, out_sat_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, ra1, ra2;
  logic [W-1:0]      mem_wd;
  logic              out_load;

  logic [1:0]        q_idx;
  logic [5:0]        idx3;
  logic [CW-1:0]     fld;
  logic [W-1:0]      sub_res, acc_nxt, dmag, nmag, prod_ext, prod_sh;
  logic [CB-1:0]     chunk;
  logic signed [CB:0]   ma;
  logic signed [CW+1:0] mb;
  logic signed [PW-1:0] prod;
  logic [DW:0]       trial;
  logic              ge;
  logic              sat_pos, sat_neg, qsat;
  logic [CW-1:0]     qval;

  assign ins   = ucode(pc_r);
  assign q_idx = q_data[2:1];
  assign idx3  = {3'b0, q_idx, 1'b0} + {4'b0, q_idx};

  // field of the queued request picked by the word counter
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    fld = q_data[3 +: CW];
      3'd1:    fld = q_data[3 + CW +: CW];
      3'd2:    fld = q_data[3 + 2 * CW +: CW];
      3'd3:    fld = q_data[3 + 3 * CW +: CW];
      3'd4:    fld = q_data[3 + 4 * CW +: CW];
      default: fld = q_data[3 + 5 * CW +: CW];
    endcase
  end

  // datapath arithmetic
  assign sub_res  = rd1_r - rd2_r;
  assign chunk    = rd1_r[ch_r * CB +: CB];
  assign ma       = (ch_r == 2'd2) ? {chunk[CB-1], chunk} : {1'b0, chunk};
  assign mb       = rd2_r[CW+1:0];
  assign prod     = ma * mb;
  assign prod_ext = {{(W - PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    case (ch_r)
      2'd0:    prod_sh = prod_ext;
      2'd1:    prod_sh = prod_ext << CB;
      default: prod_sh = prod_ext << (2 * CB);
    endcase
  end

  always_comb begin
    case (ins.op)
      OP_MLA:  acc_nxt = acc_r + msum_r;
      OP_MLS:  acc_nxt = acc_r - msum_r;
      default: acc_nxt = msum_r;
    endcase
  end

  assign dmag  = rd1_r[W-1] ? (~rd1_r + 1'b1) : rd1_r;
  assign nmag  = dmag;
  assign trial = {rem_r[DW-1:0], q_r[W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  // saturation of the quotient magnitude
  always_comb begin
    sat_pos = |q_r[W-1:CW-1];
    sat_neg = (|q_r[W-1:CW]) || (q_r[CW-1] && (|q_r[CW-2:0]));
    qsat    = qneg_r ? sat_neg : sat_pos;
    if (qneg_r) begin
      qval = sat_neg ? {1'b1, {(CW - 1){1'b0}}} : (~q_r[CW-1:0] + 1'b1);
    end else begin
      qval = sat_pos ? {1'b0, {(CW - 1){1'b1}}} : q_r[CW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (item_kind_t'(q_data[0]) == KIND_QUERY) ? ST_PWR : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_r == CNTW'(5)) state_nxt = ST_IDLE;
      end
      ST_PWR: begin
        if (cnt_r == CNTW'(2)) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (ins.op)
          OP_SUB:  state_nxt = ST_FETCH;
          OP_MUL:  state_nxt = ST_MUL;
          OP_MLA:  state_nxt = ST_MUL;
          OP_MLS:  state_nxt = ST_MUL;
          OP_CHKD: state_nxt = (rd1_r == '0) ? ST_OUT : ST_FETCH;
          OP_DIV:  state_nxt = ST_DIV;
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (ch_r == 2'd2) ? ST_WB : ST_MUL;
      ST_WB:  state_nxt = ST_FETCH;
      ST_DIV: begin
        if (cnt_r == CNTW'(W - 1)) state_nxt = ST_DFIN;
      end
      ST_DFIN: state_nxt = ST_FETCH;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: scratch port, queue pop, result load
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = ins.d;
    mem_wd   = sub_res;
    ra1      = ins.s1;
    ra2      = ins.s2;
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_LOAD: begin
        mem_we = 1'b1;
        mem_wd = {{(W - CW){fld[CW-1]}}, fld};
        if (cnt_r < CNTW'(3)) begin
          mem_wa = idx3 + 6'(cnt_r);
        end else begin
          mem_wa = A_VEL + idx3 + 6'(cnt_r) - 6'd3;
        end
        q_pop = (cnt_r == CNTW'(5));
      end
      ST_PWR: begin
        mem_we = 1'b1;
        mem_wd = {{(W - CW){fld[CW-1]}}, fld};
        mem_wa = A_P + 6'(cnt_r);
        q_pop  = (cnt_r == CNTW'(2));
      end
      ST_EXEC: begin
        mem_we = (ins.op == OP_SUB);
      end
      ST_WB: begin
        mem_we = 1'b1;
        mem_wd = acc_nxt;
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // scratch memory, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd1_r <= mem_r[ra1];
    rd2_r <= mem_r[ra2];
  end

  // control registers
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencer datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cnt_r <= '0;
      end
      ST_LOAD: begin
        cnt_r <= cnt_r + 1'b1;
      end
      ST_PWR: begin
        cnt_r   <= cnt_r + 1'b1;
        pc_r    <= '0;
        sat_r   <= 1'b0;
        degen_r <= 1'b0;
      end
      ST_EXEC: begin
        case (ins.op)
          OP_SUB: pc_r <= pc_r + 1'b1;
          OP_MUL, OP_MLA, OP_MLS: begin
            msum_r <= '0;
            ch_r   <= 2'd0;
          end
          OP_CHKD: begin
            if (rd1_r == '0) begin
              degen_r <= 1'b1;
              res_x_r <= '0;
              res_y_r <= '0;
              res_z_r <= '0;
            end
            den_r  <= dmag[DW-1:0];
            dneg_r <= rd1_r[W-1];
            pc_r   <= pc_r + 1'b1;
          end
          OP_DIV: begin
            qneg_r <= rd1_r[W-1] ^ dneg_r;
            q_r    <= nmag;
            rem_r  <= '0;
            cnt_r  <= '0;
          end
          default: begin
            cnt_r <= '0;
          end
        endcase
      end
      ST_MUL: begin
        prod_r <= prod;
      end
      ST_ACC: begin
        msum_r <= msum_r + prod_sh;
        ch_r   <= ch_r + 1'b1;
      end
      ST_WB: begin
        acc_r <= acc_nxt;
        pc_r  <= pc_r + 1'b1;
      end
      ST_DIV: begin
        rem_r <= ge ? (trial - {1'b0, den_r}) : trial;
        q_r   <= {q_r[W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_DFIN: begin
        case (ins.d[1:0])
          2'd0:    res_x_r <= qval;
          2'd1:    res_y_r <= qval;
          default: res_z_r <= qval;
        endcase
        sat_r <= sat_r | qsat;
        pc_r  <= pc_r + 1'b1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_z_r     <= res_z_r;
      out_degen_r <= degen_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUTW'({out_z_r, out_y_r, out_x_r});
  assign out_tuser  = {out_sat_r, out_degen_r};

`ifndef NO_ASSERTIONS
  // a degenerate result carries zero velocity and no clip flag
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_degen_r |->
      (out_x_r == '0 && out_y_r == '0 && out_z_r == '0 && !out_sat_r))
    else $error("degenerate result not zero");

  // no scratch write while waiting for a request or for the result slot
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_OUT) |-> !mem_we)
    else $error("scratch write while idle");

  // a request is popped once
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("queue popped twice");

  // divider never runs past its bit count
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CNTW'(W))
    else $error("divider overran");
`endif

endmodule

`default_nettype wire

>>> rtl/tetrahedron_barycentric_interpolator_unit.sv
`default_nettype none

// channel | direction | tdata (low bit up)                        | tuser
// in_     | slave     | vertex_index, pos_x/y/z, load_vel_x/y/z   | req_type
// out_    | master    | result_vel_x, result_vel_y, result_vel_z  | degenerate, saturated
//
// a load in the back end is one dispatch step and six scratch writes through one
//   write port
// a query runs 48 products on a 3-chunk multiply loop and three 4*COORD_WIDTH+10 bit
//   restoring divides
// reset (rst_n low, synchronous) empties the queue and result slot; vertex store
//   is undefined until loaded
// a two-entry queue lets the input side accept while the back end works or the
//   result waits for out_tready
module tetrahedron_barycentric_interpolator_unit
  import tbi_pkg::*;
#(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // vertex_index, pos_x, pos_y, pos_z, load_vel_x, load_vel_y, load_vel_z, zero pad
  input  wire logic [((6 * COORD_WIDTH + 9) / 8) * 8 - 1:0] in_tdata,
  // req_type
  input  wire logic in_tuser,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // result_vel_x, result_vel_y, result_vel_z, zero pad
  output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // degenerate, saturated
  output logic [1:0] out_tuser
);

  localparam int INW  = ((6 * COORD_WIDTH + 9) / 8) * 8;
  localparam int OUTW = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int EW   = 3 + 6 * COORD_WIDTH;

  logic          ent_valid, ent_ready;
  logic [EW-1:0] ent_data;
  logic          q_valid, q_pop;
  logic [EW-1:0] q_data;

  tbi_front #(
    .CW  (COORD_WIDTH),
    .INW (INW),
    .EW  (EW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .ent_valid (ent_valid),
    .ent_ready (ent_ready),
    .ent_data  (ent_data)
  );

  tbi_queue #(
    .EW (EW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (ent_valid),
    .push_ready (ent_ready),
    .push_data  (ent_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  tbi_back #(
    .CW   (COORD_WIDTH),
    .EW   (EW),
    .OUTW (OUTW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import tbi_pkg::*;
();

  localparam int CW = 20;
  localparam logic signed [CW-1:0] CMAX = 20'sh7FFFF;
  localparam logic signed [CW-1:0] CMIN = 20'sh80000;

  typedef logic signed [255:0] wint_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    item_kind_t  kind;
    logic [1:0]  idx;
    coord_t      pos [3];
    coord_t      vel [3];
  } request_t;

  typedef struct {
    coord_t vel [3];
    logic   degen;
    logic   sat;
  } velocity_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [127:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;

  tetrahedron_barycentric_interpolator_unit #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  request_t  pending_reqs [$];
  velocity_t expected_vels [$];
  coord_t    vert_pos [4][3];
  coord_t    vert_vel [4][3];
  int        n_sent, n_accepted, n_loads, n_queries, n_degen, n_sat, n_results;
  int        n_errors;
  int        cyc;
  bit        in_taken;
  bit        quiet;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // u.(v x t) in wide signed arithmetic
  function automatic wint_t triple(input wint_t u0, u1, u2, v0, v1, v2, t0, t1, t2);
    return u0 * (v1 * t2 - v2 * t1) + u1 * (v2 * t0 - v0 * t2) + u2 * (v0 * t1 - v1 * t0);
  endfunction

  // barycentric interpolation over the current vertex store
  function automatic velocity_t interpolate(input coord_t p_in [3]);
    velocity_t r;
    wint_t a [3], b [3], c [3], d [3], p [3];
    wint_t ba [3], ca [3], dc [3], pa [3], cp [3], bp [3], dp [3];
    wint_t vol, w [4], acc, q;
    for (int i = 0; i < 3; i++) begin
      a[i] = vert_pos[0][i];
      b[i] = vert_pos[1][i];
      c[i] = vert_pos[2][i];
      d[i] = vert_pos[3][i];
      p[i] = p_in[i];
      ba[i] = b[i] - a[i];
      ca[i] = c[i] - a[i];
      dc[i] = d[i] - c[i];
      pa[i] = p[i] - a[i];
      cp[i] = c[i] - p[i];
      bp[i] = b[i] - p[i];
      dp[i] = d[i] - p[i];
    end
    r.degen = 1'b0;
    r.sat = 1'b0;
    vol = triple(ca[0], ca[1], ca[2], ba[0], ba[1], ba[2], dc[0], dc[1], dc[2]);
    if (vol == 0) begin
      r.degen = 1'b1;
      for (int i = 0; i < 3; i++) r.vel[i] = '0;
      return r;
    end
    w[0] = triple(cp[0], cp[1], cp[2], bp[0], bp[1], bp[2], dc[0], dc[1], dc[2]);
    w[1] = triple(ca[0], ca[1], ca[2], pa[0], pa[1], pa[2], dc[0], dc[1], dc[2]);
    w[2] = triple(pa[0], pa[1], pa[2], ba[0], ba[1], ba[2], dp[0], dp[1], dp[2]);
    w[3] = vol - w[0] - w[1] - w[2];
    for (int ax = 0; ax < 3; ax++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc = acc + w[k] * wint_t'(vert_vel[k][ax]);
      // signed division truncates toward zero
      q = acc / vol;
      if (q > wint_t'(CMAX)) begin
        r.vel[ax] = CMAX;
        r.sat = 1'b1;
      end else if (q < wint_t'(CMIN)) begin
        r.vel[ax] = CMIN;
        r.sat = 1'b1;
      end else begin
        r.vel[ax] = q[CW-1:0];
      end
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    int m;
    m = $urandom_range(99);
    if (m < 55) return coord_t'($signed($urandom_range(8191)) - 4096);
    if (m < 85) return coord_t'($urandom);
    case ($urandom_range(3))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic request_t mk_req(input item_kind_t kind, input logic [1:0] idx,
                                      input coord_t px, py, pz, vx, vy, vz);
    request_t r;
    r.kind = kind;
    r.idx = idx;
    r.pos[0] = px;
    r.pos[1] = py;
    r.pos[2] = pz;
    r.vel[0] = vx;
    r.vel[1] = vy;
    r.vel[2] = vz;
    return r;
  endfunction

  function automatic request_t rand_req(input item_kind_t kind, input logic [1:0] idx);
    return mk_req(kind, idx, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic push(input request_t r);
    pending_reqs.insert(pending_reqs.size(), r);
    n_sent++;
  endtask

  // reset and stimulus
  initial begin
    request_t r;
    int order [4];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;

    // unit tetrahedron, vertex b carries extreme velocity
    push(mk_req(KIND_LOAD, 2'd0, 0, 0, 0, 20'sd256, -20'sd256, 0));
    push(mk_req(KIND_LOAD, 2'd1, 20'sd256, 0, 0, CMAX, CMIN, 20'sd1));
    push(mk_req(KIND_LOAD, 2'd2, 0, 20'sd256, 0, 0, 20'sd512, CMIN));
    push(mk_req(KIND_LOAD, 2'd3, 0, 0, 20'sd256, CMAX, 0, CMAX));
    // inside, at a vertex, far out both ways (overflow in both directions)
    push(mk_req(KIND_QUERY, 2'd0, 20'sd64, 20'sd64, 20'sd64, '1, '1, '1));
    push(mk_req(KIND_QUERY, 2'd3, 0, 0, 0, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd0, CMAX, 0, 0, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd0, CMIN, 0, 0, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd1, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    push(mk_req(KIND_QUERY, 2'd2, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    // extreme vertex positions
    push(mk_req(KIND_LOAD, 2'd0, CMIN, CMIN, CMIN, CMIN, CMAX, 0));
    push(mk_req(KIND_LOAD, 2'd1, CMAX, CMIN, CMIN, CMAX, CMIN, '1));
    push(mk_req(KIND_LOAD, 2'd2, CMIN, CMAX, CMIN, '1, 0, CMAX));
    push(mk_req(KIND_LOAD, 2'd3, CMIN, CMIN, CMAX, 0, '1, CMIN));
    push(mk_req(KIND_QUERY, 2'd0, 0, 0, 0, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd0, CMAX, CMAX, CMAX, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd0, CMIN, CMIN, CMIN, 0, 0, 0));
    // flat tetrahedron: zero volume
    push(mk_req(KIND_LOAD, 2'd3, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX));
    push(mk_req(KIND_QUERY, 2'd0, 20'sd5, -20'sd7, 20'sd9, 0, 0, 0));
    push(mk_req(KIND_LOAD, 2'd3, CMAX, CMAX, CMAX, 0, 0, 0));
    push(mk_req(KIND_QUERY, 2'd1, 20'sd1, 20'sd2, 20'sd3, 0, 0, 0));

    // random: mostly whole tetrahedra followed by queries, some stray requests
    while (n_sent < 1750) begin
      if ($urandom_range(99) < 70) begin
        for (int i = 0; i < 4; i++) order[i] = i;
        order.shuffle();
        for (int i = 0; i < 4; i++) push(rand_req(KIND_LOAD, 2'(order[i])));
        repeat ($urandom_range(1, 3)) push(rand_req(KIND_QUERY, 2'($urandom_range(3))));
      end else begin
        r = rand_req($urandom_range(1) ? KIND_QUERY : KIND_LOAD, 2'($urandom_range(3)));
        push(r);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_sent) @(posedge clk);
    while (expected_vels.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d loads and %0d queries; %0d results checked", n_loads, n_queries,
             n_results);
    $display("%0d degenerate and %0d saturated results, %0d mismatches", n_degen, n_sat,
             n_errors);
    if (n_errors == 0) begin
      $display("[tetrahedron_barycentric_interpolator_unit] OK");
    end else begin
      $display("[tetrahedron_barycentric_interpolator_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("[tetrahedron_barycentric_interpolator_unit] ERROR");
    $finish;
  end

  // request driver and ready toggling, both on the falling edge
  always @(negedge clk) begin
    request_t r;
    cyc = cyc + 1;
    quiet = (cyc >= 60000 && cyc < 100000);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= r.kind;
        in_tdata <= {6'b0, r.vel[2], r.vel[1], r.vel[0], r.pos[2], r.pos[1], r.pos[0], r.idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && (quiet || $urandom_range(99) >= 28);
  end

  // accept requests, predict, and check results
  always @(posedge clk) begin
    coord_t    p [3];
    logic [1:0] idx;
    velocity_t e;
    velocity_t got;
    in_taken = in_tvalid && in_tready;
    if (in_taken) begin
      n_accepted++;
      idx = in_tdata[1:0];
      for (int i = 0; i < 3; i++) p[i] = in_tdata[2 + 20*i +: 20];
      if (item_kind_t'(in_tuser) == KIND_LOAD) begin
        n_loads++;
        for (int i = 0; i < 3; i++) begin
          vert_pos[idx][i] = p[i];
          vert_vel[idx][i] = in_tdata[62 + 20*i +: 20];
        end
      end else begin
        n_queries++;
        e = interpolate(p);
        if (e.degen) n_degen++;
        if (e.sat) n_sat++;
        expected_vels.insert(expected_vels.size(), e);
      end
    end
    if (out_tvalid && out_tready) begin
      n_results++;
      for (int i = 0; i < 3; i++) got.vel[i] = out_tdata[20*i +: 20];
      got.degen = out_tuser[0];
      got.sat = out_tuser[1];
      if (expected_vels.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %0d %0d %0d", got.vel[0], got.vel[1],
                                     got.vel[2]);
      end else begin
        e = expected_vels.pop_front();
        if (got.vel[0] !== e.vel[0] || got.vel[1] !== e.vel[1] || got.vel[2] !== e.vel[2] ||
            got.degen !== e.degen || got.sat !== e.sat) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d: exp vel %0d %0d %0d degen %b sat %b, got %0d %0d %0d %b %b",
                     n_results, e.vel[0], e.vel[1], e.vel[2], e.degen, e.sat,
                     got.vel[0], got.vel[1], got.vel[2], got.degen, got.sat);
        end
      end
    end
  end

endmodule
